// ===== rtl/core/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// shared constants and types for the max frequency stack
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_W        = 32;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/mfs_in_if.sv =====
// ----------------------------------------------------------------------------
// mfs_in_if
// request channel: operation and value
// ----------------------------------------------------------------------------
`default_nettype none

interface mfs_in_if import mfs_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [FIELD_W-1:0] value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mfs_out_if.sv =====
// ----------------------------------------------------------------------------
// mfs_out_if
// response channel: popped value and status
// ----------------------------------------------------------------------------
`default_nettype none

interface mfs_out_if import mfs_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] popped_value;
    logic [1:0]                status;

    modport source (output valid, popped_value, status, input ready);
    modport sink   (input valid, popped_value, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mfs_ram.sv =====
// ----------------------------------------------------------------------------
// mfs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/max_frequency_stack.sv =====
// ----------------------------------------------------------------------------
// max_frequency_stack
// stack that pops the most frequent value, newest first among equals
// ----------------------------------------------------------------------------
// A push counts one more occurrence of its value and files it on the stack of
// that count level; a pop removes the newest entry of the highest level and
// lowers that value's count. Three rams hold the state: a key table
// {valid, count, value} searched by value, a slot table {key, link} that
// forms the level stacks and the free list, and a level head table. After
// reset a clearing pass over all CAPACITY entries initialises the key and slot
// tables; no beat is taken during it. A push then scans the key table linearly
// through its single read port and writes the key, slot and level head
// tables; a pop makes three dependent ram reads and one write. Pop on empty
// and push when full go straight to the response. A new request
// is taken while the previous response still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module max_frequency_stack import mfs_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mfs_in_if.sink    req,
    mfs_out_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VB = VALUE_BITS;
    localparam int KW = 1 + CW + VB;
    localparam int SW = 2 * AW;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_PUSH_RD,
        S_PUSH_WR,
        S_POP_RD0,
        S_POP_RD1,
        S_POP_RD2,
        S_POP_WR,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     cnt_reg;
    logic              issue_done_reg;
    logic              cmp_vld_reg;
    logic [AW-1:0]     cmp_idx_reg;
    logic              hit_reg;
    logic              free_found_reg;
    logic [AW-1:0]     kidx_reg;
    logic [AW-1:0]     fidx_reg;
    logic [CW-1:0]     kcnt_reg;
    logic [VB-1:0]     v_reg;
    logic [AW-1:0]     k_reg;
    logic [CW-1:0]     c_reg;
    logic [AW-1:0]     s_reg;
    logic [AW-1:0]     link_reg;
    logic [CW-1:0]     top_reg;
    logic [CW-1:0]     used_reg;
    logic [AW-1:0]     free_head_reg;
    status_t           res_status_reg;
    logic [FIELD_W-1:0] res_value_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [FIELD_W-1:0] out_value_reg;

    // ram ports
    logic          key_we, slot_we, lh_we;
    logic [AW-1:0] key_waddr, key_raddr, slot_waddr, slot_raddr, lh_waddr, lh_raddr;
    logic [KW-1:0] key_wdata, key_rdata;
    logic [SW-1:0] slot_wdata, slot_rdata;
    logic [AW-1:0] lh_wdata, lh_rdata;

    mfs_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    mfs_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    mfs_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_level_ram (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata)
    );

    // key word fields
    logic          key_rd_valid;
    logic [CW-1:0] key_rd_count;
    logic [VB-1:0] key_rd_value;
    assign key_rd_valid = key_rdata[KW-1];
    assign key_rd_count = key_rdata[KW-2:VB];
    assign key_rd_value = key_rdata[VB-1:0];

    // slot word fields
    logic [AW-1:0] slot_rd_key, slot_rd_link;
    assign slot_rd_key  = slot_rdata[SW-1:AW];
    assign slot_rd_link = slot_rdata[AW-1:0];

    // request value brought to VALUE_BITS
    logic [63:0]   in_ext;
    logic [VB-1:0] in_v;
    assign in_ext = {{(64 - FIELD_W){req.value[FIELD_W-1]}}, req.value};
    assign in_v   = in_ext[VB-1:0];

    // popped value sign extended back to the field width
    logic signed [VB-1:0] pop_sv;
    logic [63:0]          pop_ext;
    assign pop_sv  = key_rd_value;
    assign pop_ext = 64'(pop_sv);

    // push choice after the scan
    logic [AW-1:0] push_k;
    logic [CW-1:0] push_c;
    logic [CW-1:0] push_c_m1;
    logic [CW-1:0] c_m1;
    logic [CW-1:0] top_m1;
    logic [CW-1:0] kcnt_m1;
    assign push_k    = hit_reg ? kidx_reg : fidx_reg;
    assign push_c    = hit_reg ? kcnt_reg + CW'(1) : CW'(1);
    assign push_c_m1 = push_c - CW'(1);
    assign c_m1      = c_reg - CW'(1);
    assign top_m1    = top_reg - CW'(1);
    assign kcnt_m1   = key_rd_count - CW'(1);

    logic [AW-1:0] init_next;
    assign init_next = (cnt_reg == AW'(CAPACITY - 1)) ? '0 : cnt_reg + AW'(1);

    logic accept;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // response moves into the output register once that register is free
    logic load_out;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        key_we     = 1'b0;
        key_waddr  = cnt_reg;
        key_wdata  = '0;
        key_raddr  = cnt_reg;
        slot_we    = 1'b0;
        slot_waddr = cnt_reg;
        slot_wdata = {{AW{1'b0}}, init_next};
        slot_raddr = free_head_reg;
        lh_we      = 1'b0;
        lh_waddr   = top_m1[AW-1:0];
        lh_wdata   = link_reg;
        lh_raddr   = top_m1[AW-1:0];
        case (state_reg)
            S_INIT:
            begin
                key_we  = 1'b1;
                slot_we = 1'b1;
            end
            S_PUSH_RD:
            begin
                // key entry update, then fetch free slot link and level head
                key_we     = 1'b1;
                key_waddr  = push_k;
                key_wdata  = {1'b1, push_c, v_reg};
                slot_raddr = free_head_reg;
                lh_raddr   = push_c_m1[AW-1:0];
            end
            S_PUSH_WR:
            begin
                slot_we    = 1'b1;
                slot_waddr = free_head_reg;
                slot_wdata = {k_reg, (c_reg <= top_reg) ? lh_rdata : free_head_reg};
                lh_we      = 1'b1;
                lh_waddr   = c_m1[AW-1:0];
                lh_wdata   = free_head_reg;
            end
            S_POP_RD1:
            begin
                slot_raddr = lh_rdata;
            end
            S_POP_RD2:
            begin
                key_raddr = slot_rd_key;
            end
            S_POP_WR:
            begin
                key_we     = 1'b1;
                key_waddr  = k_reg;
                key_wdata  = {(kcnt_m1 != '0), kcnt_m1, key_rd_value};
                slot_we    = 1'b1;
                slot_waddr = s_reg;
                slot_wdata = {k_reg, free_head_reg};
                // level keeps entries unless the popped slot was its last
                lh_we      = (link_reg != s_reg);
                lh_waddr   = top_m1[AW-1:0];
                lh_wdata   = link_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            top_reg        <= '0;
            used_reg       <= '0;
            free_head_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_value_reg  <= res_value_reg;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    cnt_reg <= init_next;
                    if (cnt_reg == AW'(CAPACITY - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    res_value_reg  <= '0;
                    cnt_reg        <= '0;
                    issue_done_reg <= 1'b0;
                    cmp_vld_reg    <= 1'b0;
                    hit_reg        <= 1'b0;
                    free_found_reg <= 1'b0;
                    v_reg          <= in_v;
                    if (accept)
                    begin
                        if (req.op == OP_POP)
                        begin
                            if (top_reg == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_POP_RD0;
                            end
                        end
                        else if (used_reg >= CW'(CAPACITY))
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // issue one read per cycle, compare its result in the next cycle
                    cmp_vld_reg <= !issue_done_reg;
                    cmp_idx_reg <= cnt_reg;
                    if (!issue_done_reg)
                    begin
                        if (cnt_reg == AW'(CAPACITY - 1))
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + AW'(1);
                        end
                    end
                    if (cmp_vld_reg)
                    begin
                        if (key_rd_valid && key_rd_value == v_reg)
                        begin
                            hit_reg  <= 1'b1;
                            kidx_reg <= cmp_idx_reg;
                            kcnt_reg <= key_rd_count;
                        end
                        else if (!key_rd_valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            fidx_reg       <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == AW'(CAPACITY - 1))
                        begin
                            state_reg <= S_PUSH_RD;
                        end
                    end
                end
                S_PUSH_RD:
                begin
                    k_reg     <= push_k;
                    c_reg     <= push_c;
                    state_reg <= S_PUSH_WR;
                end
                S_PUSH_WR:
                begin
                    free_head_reg  <= slot_rd_link;
                    if (c_reg > top_reg)
                    begin
                        top_reg <= c_reg;
                    end
                    used_reg       <= used_reg + CW'(1);
                    res_status_reg <= ST_PUSHED;
                    state_reg      <= S_DONE;
                end
                S_POP_RD0:
                begin
                    state_reg <= S_POP_RD1;
                end
                S_POP_RD1:
                begin
                    s_reg     <= lh_rdata;
                    state_reg <= S_POP_RD2;
                end
                S_POP_RD2:
                begin
                    k_reg     <= slot_rd_key;
                    link_reg  <= slot_rd_link;
                    state_reg <= S_POP_WR;
                end
                S_POP_WR:
                begin
                    if (link_reg == s_reg)
                    begin
                        top_reg <= top_m1;
                    end
                    free_head_reg  <= s_reg;
                    used_reg       <= used_reg - CW'(1);
                    res_value_reg  <= pop_ext[FIELD_W-1:0];
                    res_status_reg <= ST_POPPED;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    // hand the beat over once the output register is free
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.popped_value = out_value_reg;

    // occupancy never exceeds the slot count
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(CAPACITY))
        else $error("slot occupancy above capacity");

    // top level is zero exactly when no slot is used
    a_top_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg == '0) == (used_reg == '0))
        else $error("top level and occupancy disagree");

    // top level never exceeds the number of slots in use
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= used_reg)
        else $error("top level above occupancy");

    // a pop that finds an empty stack leaves the free list alone
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_POP && top_reg == '0) |=> $stable(free_head_reg))
        else $error("empty pop touched the free list");

endmodule

`default_nettype wire
